/* rtl/core/dep_pkg.sv */
package dep_pkg;

  localparam int TIMER_BITS   = 16;
  localparam int NUM_CHANNELS = 2;
  localparam int QUEUE_DEPTH  = 4;

  localparam int CM_W = 8;
  localparam int MM_W = 14;

  localparam logic [0:0] FUNC_CAPTURE = 1'b0;
  localparam logic [0:0] FUNC_TRIGGER = 1'b1;

  localparam int TICKS_PER_CM = 58;
  localparam int MM_PER_CM    = 10;
  localparam int CM_MAX       = 255;

  // ticks / 58 as (ticks * CM_RECIP) >> CM_SHIFT, exact for 16-bit ticks
  localparam int               CM_SHIFT  = 22;
  localparam int               CM_RECIP_W = 17;
  localparam logic [16:0]      CM_RECIP  = 17'd72316;
  localparam int               CM_PROD_W = TIMER_BITS + CM_RECIP_W;
  localparam int               CM_QUO_W  = CM_PROD_W - CM_SHIFT;

  // ticks * 10 / 58 = ticks * 5 / 29 as (ticks * MM_RECIP) >> MM_SHIFT
  localparam int               MM_SHIFT  = 24;
  localparam int               MM_RECIP_W = 22;
  localparam logic [21:0]      MM_RECIP  = 22'd2892625;
  localparam int               MM_PROD_W = TIMER_BITS + MM_RECIP_W;

  typedef struct packed {
    logic [0:0]            channel;
    logic [TIMER_BITS-1:0] ticks;
  } meas_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/dep_req_if.sv */
interface dep_req_if;
  import dep_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [0:0]            func;
  logic [0:0]            channel;
  logic [TIMER_BITS-1:0] capture_time;

  modport source (output valid, output func, output channel, output capture_time,
                  input ready);
  modport sink (input valid, input func, input channel, input capture_time,
                output ready);
endinterface

/* rtl/core/dep_rsp_if.sv */
interface dep_rsp_if;
  import dep_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [0:0]            out_channel;
  logic [TIMER_BITS-1:0] echo_ticks;
  logic [CM_W-1:0]       distance_cm;
  logic [MM_W-1:0]       distance_mm;

  modport source (output valid, output out_channel, output echo_ticks,
                  output distance_cm, output distance_mm, input ready);
  modport sink (input valid, input out_channel, input echo_ticks,
                input distance_cm, input distance_mm, output ready);
endinterface

/* rtl/core/dep_front.sv */
module dep_front #(
  parameter int NUM_CHANNELS = dep_pkg::NUM_CHANNELS
) (
  input  logic             clk,
  input  logic             rst,
  dep_req_if.sink          req,
  input  dep_pkg::q_stat_t q_stat,
  output logic             push,
  output dep_pkg::meas_t   push_data
);
  import dep_pkg::*;

  logic [NUM_CHANNELS-1:0] awaiting_fall;
  logic [NUM_CHANNELS-1:0] awaiting_fall_next;
  logic [NUM_CHANNELS-1:0] armed;
  logic [NUM_CHANNELS-1:0] armed_next;
  logic [NUM_CHANNELS-1:0] hit;
  logic [TIMER_BITS-1:0]   rise_time [NUM_CHANNELS];
  logic                    take;
  logic                    trigger;

  assign req.ready = !q_stat.full;
  assign take      = req.valid && req.ready;
  assign trigger   = take && (req.func == FUNC_TRIGGER);

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit[i] = take && (req.func == FUNC_CAPTURE) && (int'(req.channel) == i) && armed[i];
    end
  end

  always_comb begin
    push_data.channel = req.channel;
    push_data.ticks   = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (hit[i]) begin
        push_data.ticks = req.capture_time - rise_time[i];
      end
    end
    push = |(hit & awaiting_fall);
  end

  always_comb begin
    awaiting_fall_next = awaiting_fall;
    armed_next         = armed;
    if (trigger) begin
      awaiting_fall_next = '0;
      armed_next         = '1;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (hit[i]) begin
          // first capture records the rise, second closes the measurement
          awaiting_fall_next[i] = !awaiting_fall[i];
          armed_next[i]         = !awaiting_fall[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_fall <= '0;
      armed         <= '1;
    end else begin
      awaiting_fall <= awaiting_fall_next;
      armed         <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (hit[i] && !awaiting_fall[i]) begin
        rise_time[i] <= req.capture_time;
      end
    end
  end

endmodule

/* rtl/core/dep_queue.sv */
module dep_queue #(
  parameter int DEPTH = dep_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dep_pkg::meas_t    push_data,
  input  logic              pop,
  output dep_pkg::meas_t    pop_data,
  output dep_pkg::q_stat_t  stat
);
  import dep_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  meas_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == FULL_COUNT);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/dep_back.sv */
module dep_back (
  input  logic             clk,
  input  logic             rst,
  input  dep_pkg::meas_t   pop_data,
  input  dep_pkg::q_stat_t q_stat,
  output logic             pop,
  dep_rsp_if.source        rsp
);
  import dep_pkg::*;

  logic                  s1_valid;
  logic [0:0]            s1_channel;
  logic [TIMER_BITS-1:0] s1_ticks;
  logic [CM_PROD_W-1:0]  s1_pcm;
  logic [MM_PROD_W-1:0]  s1_pmm;
  logic                  out_free;
  logic                  s1_free;
  logic [CM_QUO_W-1:0]   cm_quo;
  logic [CM_W-1:0]       cm_sat;

  assign out_free = !rsp.valid || rsp.ready;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = !q_stat.empty && s1_free;

  assign cm_quo = s1_pcm[CM_SHIFT +: CM_QUO_W];
  assign cm_sat = (cm_quo > CM_QUO_W'(CM_MAX)) ? CM_W'(CM_MAX) : cm_quo[CM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop;
      end
      if (out_free) begin
        rsp.valid <= s1_valid;
      end
    end
  end

  // multiply by reciprocals
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_channel <= pop_data.channel;
      s1_ticks   <= pop_data.ticks;
      s1_pcm     <= CM_PROD_W'(pop_data.ticks) * CM_PROD_W'(CM_RECIP);
      s1_pmm     <= MM_PROD_W'(pop_data.ticks) * MM_PROD_W'(MM_RECIP);
    end
  end

  // saturate and hold the result
  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      rsp.out_channel <= s1_channel;
      rsp.echo_ticks  <= s1_ticks;
      rsp.distance_cm <= cm_sat;
      rsp.distance_mm <= s1_pmm[MM_SHIFT +: MM_W];
    end
  end

endmodule

/* rtl/core/dual_echo_pulse_ranger_unit.sv */
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    func, channel, capture_time
// rsp      out  valid/ready    out_channel, echo_ticks, distance_cm, distance_mm
//
// One transaction per cycle while req.ready is high; a measurement leaves rsp after the
// falling-edge capture has passed, in order, the front, queue, multiply and output stages.
// Reset clears the queue, the pipeline and the channel state (all armed).
// req.ready drops only while the queue is full; rsp stalls fill the queue.
module dual_echo_pulse_ranger_unit #(
  parameter int NUM_CHANNELS = dep_pkg::NUM_CHANNELS,
  parameter int QUEUE_DEPTH  = dep_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  dep_req_if.sink   req,
  dep_rsp_if.source rsp
);
  import dep_pkg::*;

  logic    push;
  logic    pop;
  meas_t   push_data;
  meas_t   pop_data;
  q_stat_t q_stat;

  dep_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  dep_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  dep_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .q_stat   (q_stat),
    .pop      (pop),
    .rsp      (rsp)
  );

  a_push_capture_only: assert property (@(posedge clk) disable iff (rst)
    push |-> (req.func == FUNC_CAPTURE) && req.valid && req.ready)
    else $error("measurement pushed without a capture transaction");

  a_mm_exact: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |->
      (32'(rsp.distance_mm) * TICKS_PER_CM <= 32'(rsp.echo_ticks) * MM_PER_CM) &&
      (32'(rsp.echo_ticks) * MM_PER_CM < 32'(rsp.distance_mm) * TICKS_PER_CM + TICKS_PER_CM))
    else $error("distance_mm does not match echo_ticks");

  a_cm_exact: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (32'(rsp.echo_ticks) < TICKS_PER_CM * (CM_MAX + 1)) |->
      (32'(rsp.distance_cm) * TICKS_PER_CM <= 32'(rsp.echo_ticks)) &&
      (32'(rsp.echo_ticks) < 32'(rsp.distance_cm) * TICKS_PER_CM + TICKS_PER_CM))
    else $error("distance_cm does not match echo_ticks");

  a_cm_saturate: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (32'(rsp.echo_ticks) >= TICKS_PER_CM * (CM_MAX + 1)) |->
      (32'(rsp.distance_cm) == CM_MAX))
    else $error("distance_cm not saturated");

endmodule
